// ----- design/line_frame_receiver_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// line frame receiver queue: assertion macros
// shared concurrent assertion forms, clocked on clk and muted in reset
// ----------------------------------------------------------------------------
`ifndef LINE_FRAME_RECEIVER_QUEUE_CORE_MACROS_SVH
`define LINE_FRAME_RECEIVER_QUEUE_CORE_MACROS_SVH

// consequent holds in the same cycle
`define LFRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define LFRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lfrq_pkg.sv -----
// ----------------------------------------------------------------------------
// lfrq_pkg
// shared widths, byte codes, status codes and command struct
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfrq_pkg;

  localparam int BYTE_W   = 8;
  localparam int CAP_W    = 7;
  localparam int DROP_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_BYTE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

  typedef struct packed {
    logic feed;
    logic pop;
  } lfrq_cmd_t;

endpackage

// ----- design/lfrq_ram.sv -----
// ----------------------------------------------------------------------------
// lfrq_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lfrq_feed.sv -----
// ----------------------------------------------------------------------------
// lfrq_feed
// line assembly straight into the free slot, commit on newline, drop count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfrq_feed
  import lfrq_pkg::*;
#(
  parameter int QUEUE_SLOTS   = 8,
  parameter int MAX_FRAME_LEN = 64
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  lfrq_cmd_t                                             cmd,
  input  logic [BYTE_W-1:0]                                     feed_byte,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]                        rd_slot,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                        wr_slot,
  output logic [DROP_W-1:0]                                     drop_cnt,
  output logic                                                  bmem_we,
  output logic [$clog2(QUEUE_SLOTS)+$clog2(MAX_FRAME_LEN)-1:0]  bmem_waddr,
  output logic [BYTE_W-1:0]                                     bmem_wdata,
  output logic                                                  lmem_we,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                        lmem_waddr,
  output logic [$clog2(MAX_FRAME_LEN)-1:0]                      lmem_wdata
);

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int LEN_W  = $clog2(MAX_FRAME_LEN);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);
  localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(MAX_FRAME_LEN - 1);

  logic [LEN_W-1:0]  line_len_r, line_len_nxt;
  logic              discard_r, discard_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [SLOT_W-1:0] wr_next;
  logic              count_drop;

  assign wr_next = (wr_slot_r == SLOT_LAST) ? '0 : wr_slot_r + SLOT_W'(1);

  always_comb begin
    line_len_nxt = line_len_r;
    discard_nxt  = discard_r;
    wr_slot_nxt  = wr_slot_r;
    count_drop   = 1'b0;
    bmem_we      = 1'b0;
    lmem_we      = 1'b0;
    if (cmd.feed) begin
      unique case (feed_byte)
        BYTE_CR: begin
        end
        BYTE_LF: begin
          if (discard_r) begin
            discard_nxt = 1'b0;
          end else if (line_len_r != '0) begin
            if (wr_next == rd_slot) begin
              count_drop = 1'b1;
            end else begin
              lmem_we     = 1'b1;
              wr_slot_nxt = wr_next;
            end
          end
          line_len_nxt = '0;
        end
        default: begin
          if (!discard_r) begin
            if (line_len_r >= LEN_FULL) begin
              discard_nxt  = 1'b1;
              line_len_nxt = '0;
              count_drop   = 1'b1;
            end else begin
              bmem_we      = 1'b1;
              line_len_nxt = line_len_r + LEN_W'(1);
            end
          end
        end
      endcase
    end
    drop_nxt = (count_drop && drop_r != '1) ? drop_r + DROP_W'(1) : drop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      discard_r  <= 1'b0;
      wr_slot_r  <= '0;
      drop_r     <= '0;
    end else begin
      line_len_r <= line_len_nxt;
      discard_r  <= discard_nxt;
      wr_slot_r  <= wr_slot_nxt;
      drop_r     <= drop_nxt;
    end
  end

  assign bmem_waddr = {wr_slot_r, line_len_r};
  assign bmem_wdata = feed_byte;
  assign lmem_waddr = wr_slot_r;
  assign lmem_wdata = line_len_r;
  assign wr_slot    = wr_slot_r;
  assign drop_cnt   = drop_r;

endmodule

// ----- design/lfrq_pop.sv -----
// ----------------------------------------------------------------------------
// lfrq_pop
// pop sequencer: length lookup, capacity check, byte streaming to output reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_frame_receiver_queue_core_macros.svh"

module lfrq_pop
  import lfrq_pkg::*;
#(
  parameter int QUEUE_SLOTS   = 8,
  parameter int MAX_FRAME_LEN = 64
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  lfrq_cmd_t                                             cmd,
  input  logic [$clog2(QUEUE_SLOTS)-1:0]                        wr_slot,
  input  logic [DROP_W-1:0]                                     drop_cnt,
  input  logic [CAP_W-1:0]                                      cap,
  output logic                                                  lmem_re,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                        lmem_raddr,
  input  logic [$clog2(MAX_FRAME_LEN)-1:0]                      lmem_rdata,
  output logic                                                  bmem_re,
  output logic [$clog2(QUEUE_SLOTS)+$clog2(MAX_FRAME_LEN)-1:0]  bmem_raddr,
  input  logic [BYTE_W-1:0]                                     bmem_rdata,
  output logic                                                  busy,
  output logic [$clog2(QUEUE_SLOTS)-1:0]                        rd_slot,
  output logic                                                  out_valid,
  input  logic                                                  out_stall,
  output logic [STATUS_W-1:0]                                   out_status,
  output logic [BYTE_W-1:0]                                     out_frame_byte,
  output logic                                                  out_last,
  output logic [DROP_W-1:0]                                     out_dropped_count
);

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int LEN_W  = $clog2(MAX_FRAME_LEN);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);

  localparam logic [1:0] P_IDLE   = 2'd0;
  localparam logic [1:0] P_LEN    = 2'd1;
  localparam logic [1:0] P_STREAM = 2'd2;
  localparam logic [1:0] P_FAIL   = 2'd3;

  logic [1:0]          st_r, st_nxt;
  logic [SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    iss_r, iss_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic                a_vld_r, a_vld_nxt;
  logic                a_last_r, a_last_nxt;
  logic [STATUS_W-1:0] fail_r, fail_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;
  logic [DROP_W-1:0]   out_drop_r;

  logic b_free, b_load, a_free, issue, fail_load, iss_last;

  assign b_free   = !out_valid_r || !out_stall;
  assign b_load   = (st_r == P_STREAM) && a_vld_r && b_free;
  assign a_free   = !a_vld_r || b_load;
  assign issue    = (st_r == P_STREAM) && !iss_done_r && a_free;
  assign iss_last = (iss_r == len_r - LEN_W'(1));

  always_comb begin
    st_nxt       = st_r;
    rd_slot_nxt  = rd_slot_r;
    len_nxt      = len_r;
    iss_nxt      = iss_r;
    iss_done_nxt = iss_done_r;
    a_vld_nxt    = a_vld_r;
    a_last_nxt   = a_last_r;
    fail_nxt     = fail_r;
    lmem_re      = 1'b0;
    fail_load    = 1'b0;
    unique case (st_r)
      P_IDLE: begin
        if (cmd.pop) begin
          if (rd_slot_r == wr_slot) begin
            fail_nxt = ST_EMPTY;
            st_nxt   = P_FAIL;
          end else begin
            lmem_re = 1'b1;
            st_nxt  = P_LEN;
          end
        end
      end
      P_LEN: begin
        if (cap <= CAP_W'(lmem_rdata)) begin
          fail_nxt = ST_LONG;
          st_nxt   = P_FAIL;
        end else begin
          len_nxt      = lmem_rdata;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
          st_nxt       = P_STREAM;
        end
      end
      P_STREAM: begin
        if (issue) begin
          a_vld_nxt  = 1'b1;
          a_last_nxt = iss_last;
          iss_nxt    = iss_r + LEN_W'(1);
          if (iss_last) begin
            iss_done_nxt = 1'b1;
          end
        end else if (b_load) begin
          a_vld_nxt = 1'b0;
        end
        if (iss_done_r && a_free) begin
          st_nxt      = P_IDLE;
          rd_slot_nxt = (rd_slot_r == SLOT_LAST) ? '0 : rd_slot_r + SLOT_W'(1);
        end
      end
      P_FAIL: begin
        if (b_free) begin
          fail_load = 1'b1;
          st_nxt    = P_IDLE;
        end
      end
      default: begin
        st_nxt = P_IDLE;
      end
    endcase
    if (b_load || fail_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= P_IDLE;
      rd_slot_r   <= '0;
      iss_done_r  <= 1'b0;
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_slot_r   <= rd_slot_nxt;
      iss_done_r  <= iss_done_nxt;
      a_vld_r     <= a_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    iss_r    <= iss_nxt;
    a_last_r <= a_last_nxt;
    fail_r   <= fail_nxt;
    if (b_load) begin
      out_status_r <= ST_BYTE;
      out_byte_r   <= bmem_rdata;
      out_last_r   <= a_last_r;
      out_drop_r   <= drop_cnt;
    end else if (fail_load) begin
      out_status_r <= fail_r;
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
      out_drop_r   <= drop_cnt;
    end
  end

  assign lmem_raddr        = rd_slot_r;
  assign bmem_re           = issue;
  assign bmem_raddr        = {rd_slot_r, iss_r};
  assign busy              = (st_r != P_IDLE);
  assign rd_slot           = rd_slot_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_byte    = out_byte_r;
  assign out_last          = out_last_r;
  assign out_dropped_count = out_drop_r;

  `LFRQ_ASSERT_NOW(a_pop_only_idle, cmd.pop, st_r == P_IDLE, "pop taken while busy")
  `LFRQ_ASSERT_NOW(a_stage_in_stream, a_vld_r, st_r == P_STREAM, "read stage live outside stream")
  `LFRQ_ASSERT_NOW(a_fail_is_last, out_valid_r && out_status_r != ST_BYTE, out_last_r,
    "failure result without last")
  `LFRQ_ASSERT_NEXT(a_slot_moves, st_r == P_STREAM && st_nxt == P_IDLE,
    rd_slot_r != $past(rd_slot_r), "read slot not advanced after frame")

endmodule

// ----- design/line_frame_receiver_queue_core.sv -----
// ----------------------------------------------------------------------------
// line_frame_receiver_queue_core
// newline delimited frame queue with byte feed and frame pop
// ----------------------------------------------------------------------------
// input channel (in_valid/in_stall) carries one command word per handshake:
// in_command 0 feeds in_byte_value into the line being assembled, 1 pops the
// oldest stored frame. a feed gives no output word, so feed words can arrive
// every cycle while no pop is running.
// a pop holds in_stall high while it runs. an empty queue gives one failure
// word, loaded from the fail state into the output register; a frame that is
// not shorter than the read capacity gives one failure word after the length
// lookup. otherwise the frame bytes follow the length lookup through the
// registered byte memory read into the output register, one byte per cycle
// while out_stall is low, last set on the final byte.
// out_stall holds the output register and pauses the byte stream; new input
// words are still taken in the meantime unless a pop is running.
// cfg_we writes cfg_wdata into the read capacity register (reset value 64).
// reset empties the queue, the current line and the drop counter; the
// memories need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_frame_receiver_queue_core
  import lfrq_pkg::*;
#(
  parameter int QUEUE_SLOTS   = 8,
  parameter int MAX_FRAME_LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [BYTE_W-1:0]   in_byte_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [BYTE_W-1:0]   out_frame_byte,
  output logic                out_last,
  output logic [DROP_W-1:0]   out_dropped_count
);

  localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
  localparam int LEN_W   = $clog2(MAX_FRAME_LEN);
  localparam int BADDR_W = SLOT_W + LEN_W;

  logic [CAP_W-1:0]   cap_r;
  lfrq_cmd_t          cmd;
  logic               busy;
  logic               accept;
  logic [SLOT_W-1:0]  wr_slot, rd_slot;
  logic [DROP_W-1:0]  drop_cnt;

  logic               bmem_we, bmem_re;
  logic [BADDR_W-1:0] bmem_waddr, bmem_raddr;
  logic [BYTE_W-1:0]  bmem_wdata, bmem_rdata;
  logic               lmem_we, lmem_re;
  logic [SLOT_W-1:0]  lmem_waddr, lmem_raddr;
  logic [LEN_W-1:0]   lmem_wdata, lmem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign cmd.feed = accept && (in_command == CMD_FEED);
  assign cmd.pop  = accept && (in_command == CMD_POP);

  lfrq_feed #(
    .QUEUE_SLOTS   (QUEUE_SLOTS),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_feed (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .feed_byte  (in_byte_value),
    .rd_slot    (rd_slot),
    .wr_slot    (wr_slot),
    .drop_cnt   (drop_cnt),
    .bmem_we    (bmem_we),
    .bmem_waddr (bmem_waddr),
    .bmem_wdata (bmem_wdata),
    .lmem_we    (lmem_we),
    .lmem_waddr (lmem_waddr),
    .lmem_wdata (lmem_wdata)
  );

  lfrq_pop #(
    .QUEUE_SLOTS   (QUEUE_SLOTS),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_pop (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .wr_slot           (wr_slot),
    .drop_cnt          (drop_cnt),
    .cap               (cap_r),
    .lmem_re           (lmem_re),
    .lmem_raddr        (lmem_raddr),
    .lmem_rdata        (lmem_rdata),
    .bmem_re           (bmem_re),
    .bmem_raddr        (bmem_raddr),
    .bmem_rdata        (bmem_rdata),
    .busy              (busy),
    .rd_slot           (rd_slot),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_frame_byte    (out_frame_byte),
    .out_last          (out_last),
    .out_dropped_count (out_dropped_count)
  );

  lfrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_SLOTS << LEN_W)
  ) u_byte_ram (
    .clk   (clk),
    .we    (bmem_we),
    .waddr (bmem_waddr),
    .wdata (bmem_wdata),
    .re    (bmem_re),
    .raddr (bmem_raddr),
    .rdata (bmem_rdata)
  );

  lfrq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (lmem_we),
    .waddr (lmem_waddr),
    .wdata (lmem_wdata),
    .re    (lmem_re),
    .raddr (lmem_raddr),
    .rdata (lmem_rdata)
  );

endmodule
